>>> hdl/pcd_pkg.sv
`timescale 1ns / 1ps
package pcd_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Internal widths, sized for coordinates of up to 32 bits.
  localparam int DW    = 34;  // point minus axis point
  localparam int DIRW  = 18;  // axis direction, Q1.16
  localparam int RADW  = 31;  // radius
  localparam int PW    = 52;  // d * dir and their sum
  localparam int TW    = 38;  // axial length t
  localparam int QW    = 56;  // t * dir
  localparam int RW    = 41;  // radial components and their magnitudes
  localparam int KW    = 4;   // normalising shift
  localparam int SQW   = 64;  // sum of squares
  localparam int REMW  = 36;  // square root remainder
  localparam int ROOTW = 32;  // square root
  localparam int LW    = 42;  // radial length
  localparam int NW    = 58;  // division numerator
  localparam int QB    = 17;  // quotient bits
  localparam int DSTW  = 44;  // unsaturated distance

  localparam int CFG_AW    = 5;
  localparam int REG_COUNT = 7;
  localparam logic [NW-1:0] HALF_Q16 = NW'(32768);
  localparam logic [QB-1:0] UNIT_Q16 = QB'(65536);

  typedef enum logic [2:0] {
    REG_AP_X   = 3'd0,
    REG_AP_Y   = 3'd1,
    REG_AP_Z   = 3'd2,
    REG_DIR_X  = 3'd3,
    REG_DIR_Y  = 3'd4,
    REG_DIR_Z  = 3'd5,
    REG_RADIUS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0]     ap;
    logic [2:0][DIRW-1:0] dir;
    logic [RADW-1:0]      radius;
  } cfg_t;

  // Data riding alongside the square root cells.
  typedef struct packed {
    logic [2:0][RW-1:0] a;
    logic [KW-1:0]      k;
    logic [2:0]         neg;
  } sq_side_t;

  // Data riding alongside the divider cells.
  typedef struct packed {
    logic signed [DSTW-1:0] sdist;
    logic                   on_axis;
    logic [2:0]             neg;
  } dv_side_t;

endpackage

>>> hdl/pcd_regs.sv
`timescale 1ns / 1ps
module pcd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pcd_pkg::cfg_t              cfg
);
  import pcd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ap     <= '0;
      cfg.dir    <= {DIRW'(65536), DIRW'(0), DIRW'(0)};
      cfg.radius <= RADW'(65536);
    end else if (wr) begin
      unique case (idx)
        REG_AP_X:   cfg.ap[0]  <= pwdata;
        REG_AP_Y:   cfg.ap[1]  <= pwdata;
        REG_AP_Z:   cfg.ap[2]  <= pwdata;
        REG_DIR_X:  cfg.dir[0] <= pwdata[DIRW-1:0];
        REG_DIR_Y:  cfg.dir[1] <= pwdata[DIRW-1:0];
        REG_DIR_Z:  cfg.dir[2] <= pwdata[DIRW-1:0];
        REG_RADIUS: cfg.radius <= pwdata[RADW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AP_X:   prdata = cfg.ap[0];
      REG_AP_Y:   prdata = cfg.ap[1];
      REG_AP_Z:   prdata = cfg.ap[2];
      REG_DIR_X:  prdata = 32'(cfg.dir[0]);
      REG_DIR_Y:  prdata = 32'(cfg.dir[1]);
      REG_DIR_Z:  prdata = 32'(cfg.dir[2]);
      REG_RADIUS: prdata = 32'(cfg.radius);
      default:    prdata = '0;
    endcase
  end
endmodule

>>> hdl/pcd_front.sv
`timescale 1ns / 1ps
module pcd_front #(
  parameter int COORD_WIDTH = pcd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  pcd_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output pcd_pkg::sq_side_t             side,
  output logic [pcd_pkg::SQW-1:0]       sum
);
  import pcd_pkg::*;

  localparam int CWE = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  logic signed [DW-1:0] pt [3];
  logic signed [DW-1:0] ap [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [DW-1:0] d3 [3];
  logic signed [DW-1:0] d4 [3];
  logic signed [PW-1:0] p2 [3];
  logic signed [PW-1:0] tsum;
  logic signed [TW-1:0] t3;
  logic signed [QW-1:0] q4 [3];
  logic signed [RW-1:0] r5 [3];
  logic [RW-1:0]        a5 [3];
  logic [2:0]           neg5;
  logic [RW-1:0]        amax;
  logic [KW-1:0]        kc;
  sq_side_t             s6, s7;
  logic [30:0]          sh6 [3];
  logic [61:0]          sqp [3];
  logic [SQW-1:0]       sq7 [3];
  logic [7:0]           vld;

  always_comb begin
    pt[0] = DW'(signed'(point_x[CWE-1:0]));
    pt[1] = DW'(signed'(point_y[CWE-1:0]));
    pt[2] = DW'(signed'(point_z[CWE-1:0]));
    for (int i = 0; i < 3; i++) begin
      ap[i]  = DW'(signed'(cfg.ap[i][CWE-1:0]));
      r5[i]  = RW'(d4[i]) - RW'((q4[i] + QW'(32768)) >>> 16);
      sh6[i] = 31'(s6.a[i] >> s6.k);
      sqp[i] = sh6[i] * sh6[i];
    end
    tsum = p2[0] + p2[1] + p2[2] + PW'(32768);
    amax = a5[0];
    if (a5[1] > amax) amax = a5[1];
    if (a5[2] > amax) amax = a5[2];
    kc = '0;
    for (int b = 31; b < RW; b++) begin
      if (amax[b]) kc = KW'(b - 30);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1[i]  <= pt[i] - ap[i];
      d2[i]  <= d1[i];
      p2[i]  <= PW'(d1[i]) * PW'(signed'(cfg.dir[i]));
      d3[i]  <= d2[i];
      d4[i]  <= d3[i];
      q4[i]  <= QW'(t3) * QW'(signed'(cfg.dir[i]));
      a5[i]  <= r5[i][RW-1] ? RW'(-r5[i]) : RW'(r5[i]);
      neg5[i] <= r5[i][RW-1];
      sq7[i] <= SQW'(sqp[i]);
      s6.a[i] <= a5[i];
    end
    t3      <= TW'(tsum >>> 16);
    s6.k    <= kc;
    s6.neg  <= neg5;
    s7      <= s6;
    side    <= s7;
    sum     <= sq7[0] + sq7[1] + sq7[2];
  end

  assign out_valid = vld[7];
endmodule

>>> hdl/pcd_sqrt_cell.sv
`timescale 1ns / 1ps
module pcd_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  input  pcd_pkg::sq_side_t         side_in,
  input  logic [pcd_pkg::SQW-1:0]   v_in,
  input  logic [pcd_pkg::REMW-1:0]  rem_in,
  input  logic [pcd_pkg::ROOTW-1:0] root_in,
  output logic                      valid_out,
  output pcd_pkg::sq_side_t         side_out,
  output logic [pcd_pkg::SQW-1:0]   v_out,
  output logic [pcd_pkg::REMW-1:0]  rem_out,
  output logic [pcd_pkg::ROOTW-1:0] root_out
);
  import pcd_pkg::*;

  logic [REMW-1:0] rem2, trial;
  logic            ge;

  // One root bit per cell: bring down two radicand bits and try root*4+1.
  always_comb begin
    rem2  = {rem_in[REMW-3:0], v_in[SQW-1 -: 2]};
    trial = REMW'({root_in, 2'b01});
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    v_out    <= v_in << 2;
    rem_out  <= ge ? rem2 - trial : rem2;
    root_out <= {root_in[ROOTW-2:0], ge};
  end
endmodule

>>> hdl/pcd_div_cell.sv
`timescale 1ns / 1ps
module pcd_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  pcd_pkg::dv_side_t                side_in,
  input  logic [pcd_pkg::LW-1:0]           den_in,
  input  logic [2:0][pcd_pkg::NW-1:0]      rem_in,
  input  logic [2:0][pcd_pkg::QB-1:0]      q_in,
  output logic                             valid_out,
  output pcd_pkg::dv_side_t                side_out,
  output logic [pcd_pkg::LW-1:0]           den_out,
  output logic [2:0][pcd_pkg::NW-1:0]      rem_out,
  output logic [2:0][pcd_pkg::QB-1:0]      q_out
);
  import pcd_pkg::*;

  logic [NW-1:0] dsh;
  logic [2:0]    ge;

  always_comb begin
    dsh = NW'(den_in) << SHIFT;
    for (int i = 0; i < 3; i++) begin
      ge[i] = rem_in[i] >= dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    den_out  <= den_in;
    for (int i = 0; i < 3; i++) begin
      rem_out[i] <= ge[i] ? rem_in[i] - dsh : rem_in[i];
      q_out[i]   <= {q_in[i][QB-2:0], ge[i]};
    end
  end
endmodule

>>> hdl/point_cylinder_distance_normal.sv
`timescale 1ns / 1ps
// Point against infinite cylinder: signed distance and outward unit normal.
// The cylinder (axis point, axis direction, radius) is written through the
// APB port; the user must write it only while no item is in flight, and the
// block does not enforce this. pready is always high and reads return the
// register contents. A query item is accepted at each rising edge with start
// high and busy low. busy is high only during reset, so one item can be
// accepted every cycle. The datapath has 59 register stages: each result item
// is on the result ports, marked by done for exactly one cycle, and results
// come out in query order.
// The stages are: eight front stages (subtraction, projection, radial vector,
// normalising shift, squares, sum), a chain of 32 square root cells giving
// one root bit each, one length stage, a chain of 17 divider cells giving
// one quotient bit each for all three normals, and the output register.
// The receiver cannot stall, so every result must be taken when shown.
// Reset empties the pipeline (no done is raised for items accepted before)
// and returns the registers to their reset values.
module point_cylinder_distance_normal #(
  parameter int COORD_WIDTH = pcd_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcd_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          done,
  output logic [COORD_WIDTH-1:0]        signed_distance,
  output logic signed [17:0]            normal_x,
  output logic signed [17:0]            normal_y,
  output logic signed [17:0]            normal_z,
  output logic                          on_axis
);
  import pcd_pkg::*;

  localparam int CWE = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [DSTW-1:0] DHI = DSTW'((64'sd1 <<< (CWE - 1)) - 64'sd1);
  localparam logic signed [DSTW-1:0] DLO = -DHI - DSTW'(1);

  cfg_t cfg;

  assign busy = rst;

  pcd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // Front stages up to the sum of squares.
  logic           f_valid;
  sq_side_t       f_side;
  logic [SQW-1:0] f_sum;

  pcd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst,
    .in_valid  (start && !busy),
    .point_x, .point_y, .point_z,
    .cfg,
    .out_valid (f_valid),
    .side      (f_side),
    .sum       (f_sum)
  );

  // Square root chain: each cell settles one bit of the root.
  logic             sq_valid [ROOTW+1];
  sq_side_t         sq_side  [ROOTW+1];
  logic [SQW-1:0]   sq_v     [ROOTW+1];
  logic [REMW-1:0]  sq_rem   [ROOTW+1];
  logic [ROOTW-1:0] sq_root  [ROOTW+1];

  assign sq_valid[0] = f_valid;
  assign sq_side[0]  = f_side;
  assign sq_v[0]     = f_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;

  for (genvar g = 0; g < ROOTW; g++) begin : g_sqrt
    pcd_sqrt_cell u_cell (
      .clk, .rst,
      .valid_in  (sq_valid[g]),   .side_in  (sq_side[g]),
      .v_in      (sq_v[g]),       .rem_in   (sq_rem[g]),
      .root_in   (sq_root[g]),
      .valid_out (sq_valid[g+1]), .side_out (sq_side[g+1]),
      .v_out     (sq_v[g+1]),     .rem_out  (sq_rem[g+1]),
      .root_out  (sq_root[g+1])
    );
  end

  // Length stage: undo the normalising shift, form the distance and the
  // rounded division numerators.
  sq_side_t          ls;
  logic [LW-1:0]     len;
  logic              l_valid;
  dv_side_t          l_side;
  logic [LW-1:0]     l_den;
  logic [2:0][NW-1:0] l_num;

  assign ls  = sq_side[ROOTW];
  assign len = LW'(sq_root[ROOTW]) << ls.k;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else begin
      l_valid <= sq_valid[ROOTW];
    end
  end

  always_ff @(posedge clk) begin
    l_side.sdist   <= signed'(DSTW'(len)) - signed'(DSTW'(cfg.radius));
    l_side.on_axis <= (len == '0);
    l_side.neg     <= ls.neg;
    l_den          <= len;
    for (int i = 0; i < 3; i++) begin
      l_num[i] <= (NW'(ls.a[i]) << 16) + NW'(len >> 1);
    end
  end

  // Divider chain: each cell settles one quotient bit of all three normals.
  logic               dv_valid [QB+1];
  dv_side_t           dv_side  [QB+1];
  logic [LW-1:0]      dv_den   [QB+1];
  logic [2:0][NW-1:0] dv_rem   [QB+1];
  logic [2:0][QB-1:0] dv_q     [QB+1];

  assign dv_valid[0] = l_valid;
  assign dv_side[0]  = l_side;
  assign dv_den[0]   = l_den;
  assign dv_rem[0]   = l_num;
  assign dv_q[0]     = '0;

  for (genvar g = 0; g < QB; g++) begin : g_div
    pcd_div_cell #(.SHIFT(QB - 1 - g)) u_cell (
      .clk, .rst,
      .valid_in  (dv_valid[g]),   .side_in  (dv_side[g]),
      .den_in    (dv_den[g]),     .rem_in   (dv_rem[g]),
      .q_in      (dv_q[g]),
      .valid_out (dv_valid[g+1]), .side_out (dv_side[g+1]),
      .den_out   (dv_den[g+1]),   .rem_out  (dv_rem[g+1]),
      .q_out     (dv_q[g+1])
    );
  end

  // Output stage: clamp the normals, apply signs, zero them on the axis, saturate the distance.
  dv_side_t               os;
  logic [QB-1:0]          qc [3];
  logic signed [17:0]     nc [3];
  logic signed [DSTW-1:0] dsat;

  always_comb begin
    os = dv_side[QB];
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[QB][i] > UNIT_Q16) ? UNIT_Q16 : dv_q[QB][i];
      nc[i] = os.neg[i] ? -signed'(18'(qc[i])) : signed'(18'(qc[i]));
      if (os.on_axis) nc[i] = '0;
    end
    dsat = os.sdist;
    if (os.sdist > DHI) dsat = DHI;
    if (os.sdist < DLO) dsat = DLO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    signed_distance <= COORD_WIDTH'(dsat[CWE-1:0]);
    normal_x        <= nc[0];
    normal_y        <= nc[1];
    normal_z        <= nc[2];
    on_axis         <= os.on_axis;
  end

  // A point on the axis must come out with a zero normal.
  a_axis_zero: assert property (@(posedge clk) disable iff (rst)
    done && on_axis |-> normal_x == 18'sd0 && normal_y == 18'sd0 && normal_z == 18'sd0)
    else $error("on-axis result with non-zero normal");

  // Clamped normal components stay within plus or minus one.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= 18'sd65536 && normal_x >= -18'sd65536 &&
             normal_y <= 18'sd65536 && normal_y >= -18'sd65536 &&
             normal_z <= 18'sd65536 && normal_z >= -18'sd65536)
    else $error("normal component out of range");

  // A result leaves the output stage in the cycle after the divider chain ends.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    dv_valid[QB] |=> done)
    else $error("result lost at the output stage");
endmodule
